// ===== rtl/mtsd_pkg.sv =====
// Package for the two-list descending merge block.
// Holds list sizing, command codes and the item and result structs.
// Depends on nothing; the top file imports it.
package mtsd_pkg;

    // Number of elements each list can hold.
    localparam int LIST_DEPTH = 16;

    // Element width and derived index widths.
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    // Command codes carried by an input transaction.
    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_START       = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    // Output transaction payload.
    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic                      last;
        logic                      overflow;
    } result_t;

endpackage

// ===== rtl/mtsd_ram.sv =====
// Simple dual-port RAM: one write port and one registered read port.
// Read data updates only on a read enable and holds otherwise.
// Depends on nothing.
module mtsd_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/merge_two_sorted_descending_top.sv =====
// Top level of the two-list descending merge block.
// Holds the load/merge controller and the output register; uses two mtsd_ram lists.
// Depends on mtsd_pkg and mtsd_ram.
//
//   Channel  Signals                                 Payload
//   -------  --------------------------------------  -------------------------------
//   item     item_valid, item_ready, item            command, value
//   result   result_valid, result_ready, result      merged_value, last, overflow
//
// Loads are accepted back to back.
// After a start, the block emits one result per cycle while the output is not stalled,
// paced by the registered read of the next head element from the list memory; no item
// is accepted until the last result has been placed in the output register.
// Reset clears the counts, the overflow flag and the output valid; the lists need no clearing.
// A stalled result holds the merge in place; the memory read data holds with it.
module merge_two_sorted_descending_top
    import mtsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam logic [0:0] ST_IDLE  = 1'b0;
    localparam logic [0:0] ST_MERGE = 1'b1;

    logic [0:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt1_reg, cnt1_next;
    logic [CNT_W-1:0] cnt2_reg, cnt2_next;
    logic             ovf_reg, ovf_next;
    logic             run_ovf_reg, run_ovf_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic              we1, we2, re1, re2;
    logic [ADDR_W-1:0] waddr1, waddr2, raddr1, raddr2;
    logic [VALUE_W-1:0] rdata1, rdata2;
    logic signed [VALUE_W-1:0] head1, head2;
    logic [CNT_W-1:0]  cnt1_m1, cnt1_m2, cnt2_m1, cnt2_m2;
    logic              accept, slot_free, pick_first, is_last;

    // List memories.
    mtsd_ram #(.DEPTH(LIST_DEPTH), .WIDTH(VALUE_W), .ADDR_W(ADDR_W)) u_first_ram (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (item.value),
        .re    (re1),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    mtsd_ram #(.DEPTH(LIST_DEPTH), .WIDTH(VALUE_W), .ADDR_W(ADDR_W)) u_second_ram (
        .clk   (clk),
        .we    (we2),
        .waddr (waddr2),
        .wdata (item.value),
        .re    (re2),
        .raddr (raddr2),
        .rdata (rdata2)
    );

    assign head1 = $signed(rdata1);
    assign head2 = $signed(rdata2);

    // Index arithmetic: the counts double as the merge cursors.
    assign cnt1_m1 = cnt1_reg - CNT_W'(1);
    assign cnt1_m2 = cnt1_reg - CNT_W'(2);
    assign cnt2_m1 = cnt2_reg - CNT_W'(1);
    assign cnt2_m2 = cnt2_reg - CNT_W'(2);

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign slot_free    = !out_valid_reg || result_ready;
    assign pick_first   = (cnt1_reg != '0) && ((cnt2_reg == '0) || (head1 >= head2));
    assign is_last      = pick_first ? ((cnt1_reg == CNT_W'(1)) && (cnt2_reg == '0))
                                     : ((cnt2_reg == CNT_W'(1)) && (cnt1_reg == '0));
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Load and merge control.
    always_comb
    begin
        state_next     = state_reg;
        cnt1_next      = cnt1_reg;
        cnt2_next      = cnt2_reg;
        ovf_next       = ovf_reg;
        run_ovf_next   = run_ovf_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        we1            = 1'b0;
        we2            = 1'b0;
        re1            = 1'b0;
        re2            = 1'b0;
        waddr1         = cnt1_reg[ADDR_W-1:0];
        waddr2         = cnt2_reg[ADDR_W-1:0];
        raddr1         = cnt1_m1[ADDR_W-1:0];
        raddr2         = cnt2_m1[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        CMD_LOAD_FIRST:
                        begin
                            if (cnt1_reg == CNT_W'(LIST_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                we1       = 1'b1;
                                cnt1_next = cnt1_reg + CNT_W'(1);
                            end
                        end
                        CMD_LOAD_SECOND:
                        begin
                            if (cnt2_reg == CNT_W'(LIST_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                we2       = 1'b1;
                                cnt2_next = cnt2_reg + CNT_W'(1);
                            end
                        end
                        CMD_START:
                        begin
                            // An empty merge changes nothing.
                            if ((cnt1_reg != '0) || (cnt2_reg != '0))
                            begin
                                re1          = (cnt1_reg != '0);
                                re2          = (cnt2_reg != '0);
                                run_ovf_next = ovf_reg;
                                ovf_next     = 1'b0;
                                state_next   = ST_MERGE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                // Emit the larger head and fetch the next one from that list.
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.last         = is_last;
                    out_next.overflow     = run_ovf_reg;
                    if (pick_first)
                    begin
                        out_next.merged_value = head1;
                        cnt1_next             = cnt1_m1;
                        re1                   = (cnt1_reg > CNT_W'(1));
                        raddr1                = cnt1_m2[ADDR_W-1:0];
                    end
                    else
                    begin
                        out_next.merged_value = head2;
                        cnt2_next             = cnt2_m1;
                        re2                   = (cnt2_reg > CNT_W'(1));
                        raddr2                = cnt2_m2[ADDR_W-1:0];
                    end
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt1_reg      <= cnt1_next;
            cnt2_reg      <= cnt2_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        run_ovf_reg <= run_ovf_next;
        out_reg     <= out_next;
    end

endmodule
